### hw/rtl/bpa_pkg.sv
package bpa_pkg;

  // Pages managed and orders of block size.
  localparam int PAGES = 1024;
  localparam int ORDERS = 8;
  localparam int TOP = ORDERS - 1;
  localparam int PW = $clog2(PAGES);
  localparam int LW = PW + 1;
  localparam int OW = $clog2(ORDERS);
  // Width for page arithmetic that may reach twice the larger of PAGES and a top block.
  localparam int AW = ((PW > TOP) ? PW : TOP) + 2;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  // Field widths fixed by the interface.
  localparam int CMD_W = 2;
  localparam int BYTES_W = 26;
  localparam int OFF_W = 26;
  localparam int STATUS_W = 2;
  localparam int ORD_OUT_W = 4;
  localparam int FREE_W = 11;
  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 11;
  localparam int SHIFT_MIN = 3;
  localparam int SHIFT_MAX = 16;
  localparam int MW = LW + SHIFT_MAX;

  localparam logic REG_PAGE_SHIFT = 1'b0;
  localparam logic REG_PAGE_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PS_NONE = 2'd0,
    PS_FREE = 2'd1,
    PS_USED = 2'd2
  } pstate_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INIT_START,
    OP_CLEAR,
    OP_INIT_SETUP,
    OP_INIT_MARK,
    OP_DEC_O,
    OP_INC_O,
    OP_APP1,
    OP_APP2,
    OP_UNL_RD,
    OP_UNL_WR,
    OP_AL_PREP,
    OP_AL_NEED,
    OP_AL_TAKE,
    OP_AL_SPLIT,
    OP_AL_FIN,
    OP_SET_NO_BLOCK,
    OP_SET_BAD_ADDR,
    OP_SET_NOT_ALLOC,
    OP_FR_PREP,
    OP_FR_RD,
    OP_FR_START,
    OP_FR_BUD,
    OP_FR_UNL,
    OP_FR_MERGE,
    OP_FR_FIN,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic clear_last;
    logic init_fits;
    logic o_zero;
    logic o_top;
    logic head_nil;
    logic o_gt_need;
    logic alloc_bad;
    logic free_bad;
    logic not_used;
    logic buddy_oob;
    logic buddy_ok;
    logic out_free;
  } dp_flags_t;

endpackage

### hw/rtl/bpa_ctrl.sv
module bpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpa_pkg::dp_flags_t flags_i,
  output bpa_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_INIT_START,
    S_CLEAR,
    S_INIT_SETUP,
    S_INIT_TEST,
    S_IDLE,
    S_DISPATCH,
    S_AL_CHK,
    S_AL_SRCH,
    S_AL_SPLIT,
    S_FR_CHK,
    S_FR_TEST,
    S_FR_LOOP,
    S_FR_BTEST,
    S_FR_MERGE,
    S_APP1,
    S_APP2,
    S_UNL_RD,
    S_UNL_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   busy_q, busy_d;
  bpa_pkg::op_e op;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op = op;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    busy_d = busy_q;
    op = bpa_pkg::OP_NONE;
    case (state_q)
      S_INIT_START: begin
        op = bpa_pkg::OP_INIT_START;
        state_d = S_CLEAR;
      end
      S_CLEAR: begin
        op = bpa_pkg::OP_CLEAR;
        if (flags_i.clear_last) state_d = S_INIT_SETUP;
      end
      S_INIT_SETUP: begin
        op = bpa_pkg::OP_INIT_SETUP;
        state_d = S_INIT_TEST;
      end
      S_INIT_TEST: begin
        if (flags_i.init_fits) begin
          op = bpa_pkg::OP_INIT_MARK;
          ret_d = S_INIT_TEST;
          state_d = S_APP1;
        end else if (flags_i.o_zero) begin
          state_d = busy_q ? S_DONE : S_IDLE;
        end else begin
          op = bpa_pkg::OP_DEC_O;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op = bpa_pkg::OP_CAPTURE;
          busy_d = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (flags_i.cmd)
          bpa_pkg::CMD_INIT: state_d = S_INIT_START;
          bpa_pkg::CMD_ALLOC: begin
            op = bpa_pkg::OP_AL_PREP;
            state_d = S_AL_CHK;
          end
          bpa_pkg::CMD_FREE: begin
            op = bpa_pkg::OP_FR_PREP;
            state_d = S_FR_CHK;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_AL_CHK: begin
        if (flags_i.alloc_bad) begin
          op = bpa_pkg::OP_SET_NO_BLOCK;
          state_d = S_DONE;
        end else begin
          op = bpa_pkg::OP_AL_NEED;
          state_d = S_AL_SRCH;
        end
      end
      S_AL_SRCH: begin
        if (!flags_i.head_nil) begin
          op = bpa_pkg::OP_AL_TAKE;
          ret_d = S_AL_SPLIT;
          state_d = S_UNL_RD;
        end else if (flags_i.o_top) begin
          op = bpa_pkg::OP_SET_NO_BLOCK;
          state_d = S_DONE;
        end else begin
          op = bpa_pkg::OP_INC_O;
        end
      end
      S_AL_SPLIT: begin
        if (flags_i.o_gt_need) begin
          op = bpa_pkg::OP_AL_SPLIT;
          ret_d = S_AL_SPLIT;
          state_d = S_APP1;
        end else begin
          op = bpa_pkg::OP_AL_FIN;
          state_d = S_DONE;
        end
      end
      S_FR_CHK: begin
        if (flags_i.free_bad) begin
          op = bpa_pkg::OP_SET_BAD_ADDR;
          state_d = S_DONE;
        end else begin
          op = bpa_pkg::OP_FR_RD;
          state_d = S_FR_TEST;
        end
      end
      S_FR_TEST: begin
        if (flags_i.not_used) begin
          op = bpa_pkg::OP_SET_NOT_ALLOC;
          state_d = S_DONE;
        end else begin
          op = bpa_pkg::OP_FR_START;
          state_d = S_FR_LOOP;
        end
      end
      S_FR_LOOP: begin
        if (flags_i.o_top || flags_i.buddy_oob) begin
          op = bpa_pkg::OP_FR_FIN;
          ret_d = S_DONE;
          state_d = S_APP1;
        end else begin
          op = bpa_pkg::OP_FR_BUD;
          state_d = S_FR_BTEST;
        end
      end
      S_FR_BTEST: begin
        if (flags_i.buddy_ok) begin
          op = bpa_pkg::OP_FR_UNL;
          ret_d = S_FR_MERGE;
          state_d = S_UNL_RD;
        end else begin
          op = bpa_pkg::OP_FR_FIN;
          ret_d = S_DONE;
          state_d = S_APP1;
        end
      end
      S_FR_MERGE: begin
        op = bpa_pkg::OP_FR_MERGE;
        state_d = S_FR_LOOP;
      end
      S_APP1: begin
        op = bpa_pkg::OP_APP1;
        state_d = S_APP2;
      end
      S_APP2: begin
        op = bpa_pkg::OP_APP2;
        state_d = ret_q;
      end
      S_UNL_RD: begin
        op = bpa_pkg::OP_UNL_RD;
        state_d = S_UNL_WR;
      end
      S_UNL_WR: begin
        op = bpa_pkg::OP_UNL_WR;
        state_d = ret_q;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          op = bpa_pkg::OP_EMIT;
          busy_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_START;
      ret_q <= S_IDLE;
      busy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      busy_q <= busy_d;
    end
  end

endmodule

### hw/rtl/bpa_datapath.sv
module bpa_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpa_pkg::dp_cmd_t                  cmd_i,
  output bpa_pkg::dp_flags_t                flags_o,
  input  logic [bpa_pkg::SHIFT_W-1:0]       cfg_shift_i,
  input  logic [bpa_pkg::COUNT_W-1:0]       cfg_count_i,
  input  logic [bpa_pkg::CMD_W-1:0]         in_command_i,
  input  logic [bpa_pkg::BYTES_W-1:0]       in_bytes_i,
  input  logic [bpa_pkg::OFF_W-1:0]         in_offset_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [bpa_pkg::STATUS_W-1:0]      out_status_o,
  output logic [bpa_pkg::OFF_W-1:0]         out_offset_o,
  output logic [bpa_pkg::ORD_OUT_W-1:0]     out_order_o,
  output logic [bpa_pkg::FREE_W-1:0]        out_free_pages_o,
  output logic [bpa_pkg::ORD_OUT_W-1:0]     out_largest_o,
  output logic                              out_any_o
);

  localparam int PW = bpa_pkg::PW;
  localparam int LW = bpa_pkg::LW;
  localparam int OW = bpa_pkg::OW;
  localparam int AW = bpa_pkg::AW;
  localparam int SHIFT_W_L = bpa_pkg::SHIFT_W;

  typedef struct packed {
    logic [OW-1:0]    order;
    bpa_pkg::pstate_e state;
  } meta_t;

  // Block heads: order and state of each page; list links per page.
  meta_t           meta_mem [bpa_pkg::PAGES];
  logic [LW-1:0]   next_mem [bpa_pkg::PAGES];
  logic [LW-1:0]   prev_mem [bpa_pkg::PAGES];
  meta_t           meta_rd_q;
  logic [LW-1:0]   next_rd_q;
  logic [LW-1:0]   prev_rd_q;

  logic            meta_we;
  logic [PW-1:0]   meta_wa, meta_ra;
  meta_t           meta_wd;
  logic            next_we, prev_we;
  logic [PW-1:0]   next_wa, prev_wa;
  logic [LW-1:0]   next_wd, prev_wd;

  logic [LW-1:0]   head_q [bpa_pkg::ORDERS];
  logic [LW-1:0]   tail_q [bpa_pkg::ORDERS];

  bpa_pkg::cmd_e        cmd_q;
  logic [bpa_pkg::BYTES_W-1:0] bytes_q, m_q;
  logic [bpa_pkg::OFF_W-1:0]   foff_q;
  logic [PW-1:0]   p_q, b_q, x_q, pfree_q;
  logic [OW-1:0]   o_q, need_q;
  logic [LW-1:0]   cnt_q, managed_q, free_total_q;
  logic            fbad_q;
  bpa_pkg::status_e status_q;
  logic [bpa_pkg::OFF_W-1:0] res_off_q;
  logic [OW-1:0]   res_ord_q;

  logic            out_valid_q;
  logic [bpa_pkg::STATUS_W-1:0]  out_status_q;
  logic [bpa_pkg::OFF_W-1:0]     out_offset_q;
  logic [bpa_pkg::ORD_OUT_W-1:0] out_order_q;
  logic [bpa_pkg::FREE_W-1:0]    out_free_q;
  logic [bpa_pkg::ORD_OUT_W-1:0] out_largest_q;
  logic            out_any_q;

  logic [SHIFT_W_L-1:0] sh;
  logic [AW-1:0]   size_o, split_size, b_w;
  logic [LW-1:0]   head_o, tail_o;
  logic [OW-1:0]   need_w;
  logic            left;
  logic [OW-1:0]   largest;
  logic            any;
  logic            fbad_w;
  logic [PW-1:0]   split_r;

  function automatic logic [OW-1:0] bitlen(input logic [bpa_pkg::TOP-1:0] v);
    logic [OW-1:0] n;
    n = '0;
    for (int i = 0; i < bpa_pkg::TOP; i++) begin
      if (v[i]) n = OW'(i + 1);
    end
    return n;
  endfunction

  always_comb begin
    if (cfg_shift_i < SHIFT_W_L'(bpa_pkg::SHIFT_MIN)) sh = SHIFT_W_L'(bpa_pkg::SHIFT_MIN);
    else if (cfg_shift_i > SHIFT_W_L'(bpa_pkg::SHIFT_MAX)) sh = SHIFT_W_L'(bpa_pkg::SHIFT_MAX);
    else sh = cfg_shift_i;
  end

  assign size_o = AW'(1) << o_q;
  assign split_size = AW'(1) << (o_q - OW'(1));
  assign split_r = PW'(AW'(p_q) + split_size);
  assign head_o = head_q[o_q];
  assign tail_o = tail_q[o_q];
  assign need_w = bitlen(m_q[bpa_pkg::TOP-1:0]);
  assign left = ((AW'(p_q) & size_o) == '0);
  assign b_w = left ? (AW'(p_q) + size_o) : (AW'(p_q) - size_o);
  assign fbad_w = ({1'b0, foff_q} >= (bpa_pkg::MW'(managed_q) << sh))
               || ((foff_q & ((bpa_pkg::OFF_W'(1) << sh) - bpa_pkg::OFF_W'(1))) != '0);

  always_comb begin
    largest = '0;
    any = 1'b0;
    for (int k = 0; k < bpa_pkg::ORDERS; k++) begin
      if (head_q[k] != bpa_pkg::NIL) begin
        largest = OW'(k);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    flags_o.cmd = cmd_q;
    flags_o.clear_last = (cnt_q == LW'(bpa_pkg::PAGES - 1));
    flags_o.init_fits = ((AW'(managed_q) - AW'(cnt_q)) >= size_o);
    flags_o.o_zero = (o_q == '0);
    flags_o.o_top = (o_q == OW'(bpa_pkg::TOP));
    flags_o.head_nil = (head_o == bpa_pkg::NIL);
    flags_o.o_gt_need = (o_q > need_q);
    flags_o.alloc_bad = (bytes_q == '0)
                     || (m_q >= (bpa_pkg::BYTES_W'(1) << bpa_pkg::TOP));
    flags_o.free_bad = fbad_q;
    flags_o.not_used = (meta_rd_q.state != bpa_pkg::PS_USED);
    flags_o.buddy_oob = left && (b_w >= AW'(managed_q));
    flags_o.buddy_ok = (meta_rd_q.state == bpa_pkg::PS_FREE) && (meta_rd_q.order == o_q);
    flags_o.out_free = !out_valid_q || out_ready_i;
  end

  // Memory port controls.
  always_comb begin
    meta_we = 1'b0;
    meta_wa = p_q;
    meta_wd = '{order: '0, state: bpa_pkg::PS_NONE};
    meta_ra = p_q;
    next_we = 1'b0;
    next_wa = x_q;
    next_wd = bpa_pkg::NIL;
    prev_we = 1'b0;
    prev_wa = x_q;
    prev_wd = tail_o;
    case (cmd_i.op)
      bpa_pkg::OP_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = cnt_q[PW-1:0];
      end
      bpa_pkg::OP_INIT_MARK: begin
        meta_we = 1'b1;
        meta_wa = cnt_q[PW-1:0];
        meta_wd = '{order: o_q, state: bpa_pkg::PS_FREE};
      end
      bpa_pkg::OP_APP1: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      bpa_pkg::OP_APP2: begin
        if (tail_o != bpa_pkg::NIL) begin
          next_we = 1'b1;
          next_wa = tail_o[PW-1:0];
          next_wd = LW'(x_q);
        end
      end
      bpa_pkg::OP_UNL_WR: begin
        if (prev_rd_q != bpa_pkg::NIL) begin
          next_we = 1'b1;
          next_wa = prev_rd_q[PW-1:0];
          next_wd = next_rd_q;
        end
        if (next_rd_q != bpa_pkg::NIL) begin
          prev_we = 1'b1;
          prev_wa = next_rd_q[PW-1:0];
          prev_wd = prev_rd_q;
        end
      end
      bpa_pkg::OP_AL_SPLIT: begin
        meta_we = 1'b1;
        meta_wa = split_r;
        meta_wd = '{order: o_q - OW'(1), state: bpa_pkg::PS_FREE};
      end
      bpa_pkg::OP_AL_FIN: begin
        meta_we = 1'b1;
        meta_wd = '{order: need_q, state: bpa_pkg::PS_USED};
      end
      bpa_pkg::OP_FR_RD: meta_ra = pfree_q;
      bpa_pkg::OP_FR_BUD: meta_ra = b_w[PW-1:0];
      bpa_pkg::OP_FR_MERGE: begin
        meta_we = 1'b1;
        meta_wa = (b_q < p_q) ? p_q : b_q;
      end
      bpa_pkg::OP_FR_FIN: begin
        meta_we = 1'b1;
        meta_wd = '{order: o_q, state: bpa_pkg::PS_FREE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[x_q];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[x_q];
  end

  // Working registers and list ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bpa_pkg::ORDERS; k++) begin
        head_q[k] <= bpa_pkg::NIL;
        tail_q[k] <= bpa_pkg::NIL;
      end
      managed_q <= LW'(bpa_pkg::PAGES);
      free_total_q <= '0;
      cnt_q <= '0;
      o_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        bpa_pkg::OP_CAPTURE: begin
          cmd_q <= bpa_pkg::cmd_e'(in_command_i);
          bytes_q <= in_bytes_i;
          foff_q <= in_offset_i;
          status_q <= bpa_pkg::ST_OK;
          res_off_q <= '0;
          res_ord_q <= '0;
        end
        bpa_pkg::OP_INIT_START: begin
          for (int k = 0; k < bpa_pkg::ORDERS; k++) begin
            head_q[k] <= bpa_pkg::NIL;
            tail_q[k] <= bpa_pkg::NIL;
          end
          cnt_q <= '0;
          free_total_q <= '0;
          managed_q <= (cfg_count_i > bpa_pkg::COUNT_W'(bpa_pkg::PAGES))
                     ? LW'(bpa_pkg::PAGES) : LW'(cfg_count_i);
        end
        bpa_pkg::OP_CLEAR: cnt_q <= cnt_q + LW'(1);
        bpa_pkg::OP_INIT_SETUP: begin
          cnt_q <= '0;
          o_q <= OW'(bpa_pkg::TOP);
          free_total_q <= managed_q;
        end
        bpa_pkg::OP_INIT_MARK: begin
          x_q <= cnt_q[PW-1:0];
          cnt_q <= LW'(AW'(cnt_q) + size_o);
        end
        bpa_pkg::OP_DEC_O: o_q <= o_q - OW'(1);
        bpa_pkg::OP_INC_O: o_q <= o_q + OW'(1);
        bpa_pkg::OP_APP2: begin
          if (tail_o == bpa_pkg::NIL) head_q[o_q] <= LW'(x_q);
          tail_q[o_q] <= LW'(x_q);
        end
        bpa_pkg::OP_UNL_WR: begin
          if (prev_rd_q == bpa_pkg::NIL) head_q[o_q] <= next_rd_q;
          if (next_rd_q == bpa_pkg::NIL) tail_q[o_q] <= prev_rd_q;
        end
        bpa_pkg::OP_AL_PREP: m_q <= (bytes_q - bpa_pkg::BYTES_W'(1)) >> sh;
        bpa_pkg::OP_AL_NEED: begin
          need_q <= need_w;
          o_q <= need_w;
        end
        bpa_pkg::OP_AL_TAKE: begin
          p_q <= head_o[PW-1:0];
          x_q <= head_o[PW-1:0];
        end
        bpa_pkg::OP_AL_SPLIT: begin
          o_q <= o_q - OW'(1);
          x_q <= split_r;
        end
        bpa_pkg::OP_AL_FIN: begin
          free_total_q <= free_total_q - LW'(AW'(1) << need_q);
          res_off_q <= bpa_pkg::OFF_W'(bpa_pkg::OFF_W'(p_q) << sh);
          res_ord_q <= need_q;
        end
        bpa_pkg::OP_SET_NO_BLOCK: status_q <= bpa_pkg::ST_NO_BLOCK;
        bpa_pkg::OP_SET_BAD_ADDR: status_q <= bpa_pkg::ST_BAD_ADDR;
        bpa_pkg::OP_SET_NOT_ALLOC: status_q <= bpa_pkg::ST_NOT_ALLOC;
        bpa_pkg::OP_FR_PREP: begin
          pfree_q <= PW'(foff_q >> sh);
          fbad_q <= fbad_w;
        end
        bpa_pkg::OP_FR_RD: p_q <= pfree_q;
        bpa_pkg::OP_FR_START: begin
          o_q <= meta_rd_q.order;
          free_total_q <= free_total_q + LW'(AW'(1) << meta_rd_q.order);
        end
        bpa_pkg::OP_FR_BUD: b_q <= b_w[PW-1:0];
        bpa_pkg::OP_FR_UNL: x_q <= b_q;
        bpa_pkg::OP_FR_MERGE: begin
          if (b_q < p_q) p_q <= b_q;
          o_q <= o_q + OW'(1);
        end
        bpa_pkg::OP_FR_FIN: x_q <= p_q;
        default: ;
      endcase

      if (cmd_i.op == bpa_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
        out_status_q <= status_q;
        out_offset_q <= res_off_q;
        out_order_q <= bpa_pkg::ORD_OUT_W'(res_ord_q);
        out_free_q <= bpa_pkg::FREE_W'(free_total_q);
        out_largest_q <= bpa_pkg::ORD_OUT_W'(largest);
        out_any_q <= any;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;
  assign out_order_o = out_order_q;
  assign out_free_pages_o = out_free_q;
  assign out_largest_o = out_largest_q;
  assign out_any_o = out_any_q;

  a_free_le_managed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= managed_q)
    else $error("free page total exceeds managed pages");

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q[o_q] == bpa_pkg::NIL) == (tail_q[o_q] == bpa_pkg::NIL))
    else $error("free list head and tail disagree on emptiness");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == bpa_pkg::OP_EMIT) |=> (out_valid_q && (out_status_q == $past(status_q))))
    else $error("result not presented after emit");

endmodule

### hw/rtl/buddy_page_allocator_top.sv
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          tuser: command; tdata: request_bytes, free_offset
// m_axis    out        tvalid/tready          tdata: status .. any_free (one result per request)
// apb       in         psel/penable, pready=1 page_shift at 0x0, page_count at 0x4
//
// Requests are handled one at a time by a sequencer over simple dual-port page tables.
// Init clears every page table entry in a sweep over PAGES, then marks each initial block.
// Allocate searches upward through empty orders and splits the found block down to size.
// Free merges the block with its free buddy order by order; query only reports.
// After reset the block runs an init with page_count 1024 and accepts no request until
// that init is finished; configuration writes are taken throughout.
// A result waits in the output register while the next request is already accepted.
module buddy_page_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: request_bytes[25:0], free_offset[51:26], zero pad [55:52].
  input  logic [55:0] s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: status[1:0], block_offset[27:2], block_order[31:28],
  // free_pages[42:32], largest_free_order[46:43], any_free[47].
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [bpa_pkg::SHIFT_W-1:0] page_shift_q;
  logic [bpa_pkg::COUNT_W-1:0] page_count_q;
  bpa_pkg::dp_cmd_t   cmd;
  bpa_pkg::dp_flags_t flags;

  logic [bpa_pkg::STATUS_W-1:0]  status;
  logic [bpa_pkg::OFF_W-1:0]     block_offset;
  logic [bpa_pkg::ORD_OUT_W-1:0] block_order;
  logic [bpa_pkg::FREE_W-1:0]    free_pages;
  logic [bpa_pkg::ORD_OUT_W-1:0] largest;
  logic                          any_free;

  // The configuration registers take a write in the access phase; reads are immediate.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= bpa_pkg::SHIFT_W'(10);
      page_count_q <= bpa_pkg::COUNT_W'(1024);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bpa_pkg::REG_PAGE_SHIFT) page_shift_q <= pwdata[bpa_pkg::SHIFT_W-1:0];
      else page_count_q <= pwdata[bpa_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bpa_pkg::REG_PAGE_COUNT) ? 32'(page_count_q)
                                                        : 32'(page_shift_q);

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  bpa_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .flags_o          (flags),
    .cfg_shift_i      (page_shift_q),
    .cfg_count_i      (page_count_q),
    .in_command_i     (s_axis_tuser),
    .in_bytes_i       (s_axis_tdata[25:0]),
    .in_offset_i      (s_axis_tdata[51:26]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_status_o     (status),
    .out_offset_o     (block_offset),
    .out_order_o      (block_order),
    .out_free_pages_o (free_pages),
    .out_largest_o    (largest),
    .out_any_o        (any_free)
  );

  assign m_axis_tdata = {any_free, largest, free_pages, block_order, block_offset, status};

endmodule

### tb/sv/tb_buddy_page_allocator_top.sv
module tb_buddy_page_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One request towards the allocator and the result it must produce.
  typedef struct {
    bpa_pkg::cmd_e cmd;
    logic [25:0]   bytes;
    logic [25:0]   offset;
  } alloc_req_t;

  typedef struct {
    bpa_pkg::status_e status;
    logic [25:0]      offset;
    logic [3:0]       order;
    logic [10:0]      free_pages;
    logic [3:0]       largest;
    logic             any_free;
  } alloc_res_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator_top DUT (.*);

  // 20 ns period clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Requests waiting for the driver and results still owed by the block.
  alloc_req_t req_pending[$];
  alloc_res_t res_owed[$];
  int         fail_count = 0;
  int         req_count = 0;
  int         res_count = 0;
  int         cmd_seen[4] = '{0, 0, 0, 0};
  int         status_seen[4] = '{0, 0, 0, 0};

  // The allocator's state as the testbench expects it to be.
  int shift_reg = 10;
  int count_reg = 1024;
  int managed_pages;
  int free_tot;
  int pg_ord[bpa_pkg::PAGES];
  int pg_st[bpa_pkg::PAGES];
  int nxt[bpa_pkg::PAGES];
  int prv[bpa_pkg::PAGES];
  int hd[bpa_pkg::ORDERS];
  int tl[bpa_pkg::ORDERS];

  // Offsets of blocks currently handed out, used to build sensible frees.
  logic [25:0] live_blocks[$];
  logic [25:0] freed_blocks[$];

  function automatic int eff_shift();
    if (shift_reg < bpa_pkg::SHIFT_MIN) return bpa_pkg::SHIFT_MIN;
    if (shift_reg > bpa_pkg::SHIFT_MAX) return bpa_pkg::SHIFT_MAX;
    return shift_reg;
  endfunction

  function automatic void list_add(int o, int p);
    int t;
    if (o >= bpa_pkg::ORDERS || p >= bpa_pkg::PAGES) return;
    t = tl[o];
    prv[p] = t;
    nxt[p] = bpa_pkg::PAGES;
    if (t >= bpa_pkg::PAGES) hd[o] = p;
    else nxt[t] = p;
    tl[o] = p;
  endfunction

  function automatic void list_remove(int o, int p);
    int pr, nx;
    if (o >= bpa_pkg::ORDERS || p >= bpa_pkg::PAGES) return;
    pr = prv[p];
    nx = nxt[p];
    if (pr >= bpa_pkg::PAGES) hd[o] = nx;
    else nxt[pr] = nx;
    if (nx >= bpa_pkg::PAGES) tl[o] = pr;
    else prv[nx] = pr;
    nxt[p] = bpa_pkg::PAGES;
    prv[p] = bpa_pkg::PAGES;
  endfunction

  function automatic void pages_init();
    int off;
    for (int i = 0; i < bpa_pkg::PAGES; i++) begin
      pg_ord[i] = 0;
      pg_st[i] = bpa_pkg::PS_NONE;
      nxt[i] = bpa_pkg::PAGES;
      prv[i] = bpa_pkg::PAGES;
    end
    for (int i = 0; i < bpa_pkg::ORDERS; i++) begin
      hd[i] = bpa_pkg::PAGES;
      tl[i] = bpa_pkg::PAGES;
    end
    managed_pages = (count_reg > bpa_pkg::PAGES) ? bpa_pkg::PAGES : count_reg;
    off = 0;
    for (int k = bpa_pkg::TOP; k >= 0; k--) begin
      while (managed_pages - off >= (1 << k)) begin
        pg_ord[off] = k;
        pg_st[off] = bpa_pkg::PS_FREE;
        list_add(k, off);
        off += 1 << k;
      end
    end
    free_tot = managed_pages;
  endfunction

  function automatic bpa_pkg::status_e pages_alloc(longint bytes, output longint offset,
                                                   output int order);
    int sh, need, k, p, r;
    longint pages;
    sh = eff_shift();
    offset = 0;
    order = 0;
    need = 0;
    if (bytes == 0 || bytes > (longint'(1) << (sh + bpa_pkg::TOP))) return bpa_pkg::ST_NO_BLOCK;
    pages = (bytes + (longint'(1) << sh) - 1) >> sh;
    while ((longint'(1) << need) < pages) need++;
    k = need;
    while (k < bpa_pkg::ORDERS && hd[k] >= bpa_pkg::PAGES) k++;
    if (k >= bpa_pkg::ORDERS) return bpa_pkg::ST_NO_BLOCK;
    p = hd[k];
    list_remove(k, p);
    // Halve down, queueing each right half on its own list.
    while (k > need) begin
      k--;
      r = p + (1 << k);
      if (r < bpa_pkg::PAGES) begin
        pg_ord[r] = k;
        pg_st[r] = bpa_pkg::PS_FREE;
        list_add(k, r);
      end
    end
    pg_ord[p] = need;
    pg_st[p] = bpa_pkg::PS_USED;
    free_tot -= 1 << need;
    offset = longint'(p) << sh;
    order = need;
    return bpa_pkg::ST_OK;
  endfunction

  function automatic bpa_pkg::status_e pages_free(longint off);
    int sh, p, o, b;
    sh = eff_shift();
    if (off >= (longint'(managed_pages) << sh)) return bpa_pkg::ST_BAD_ADDR;
    if ((off & ((longint'(1) << sh) - 1)) != 0) return bpa_pkg::ST_BAD_ADDR;
    p = int'(off >> sh);
    if (p >= bpa_pkg::PAGES) return bpa_pkg::ST_BAD_ADDR;
    if (pg_st[p] != bpa_pkg::PS_USED) return bpa_pkg::ST_NOT_ALLOC;
    o = pg_ord[p];
    if (o > bpa_pkg::TOP) o = bpa_pkg::TOP;
    free_tot += 1 << o;
    while (o < bpa_pkg::TOP) begin
      if ((p & ((2 << o) - 1)) == 0) begin
        b = p + (1 << o);
        // A right buddy beyond the managed pages never counts as free.
        if (b >= managed_pages) break;
      end else begin
        b = p - (1 << o);
      end
      if (b >= bpa_pkg::PAGES || pg_st[b] != bpa_pkg::PS_FREE || pg_ord[b] != o) break;
      list_remove(o, b);
      if (b < p) begin
        pg_st[p] = bpa_pkg::PS_NONE;
        pg_ord[p] = 0;
        p = b;
      end else begin
        pg_st[b] = bpa_pkg::PS_NONE;
        pg_ord[b] = 0;
      end
      o++;
    end
    pg_ord[p] = o;
    pg_st[p] = bpa_pkg::PS_FREE;
    list_add(o, p);
    return bpa_pkg::ST_OK;
  endfunction

  // Applies one request to the expected state and returns the result it gives.
  function automatic alloc_res_t predict_request(alloc_req_t rq);
    alloc_res_t res;
    longint     offset;
    int         order;
    res.status = bpa_pkg::ST_OK;
    res.offset = '0;
    res.order = '0;
    res.largest = '0;
    res.any_free = 1'b0;
    case (rq.cmd)
      bpa_pkg::CMD_INIT: pages_init();
      bpa_pkg::CMD_ALLOC: begin
        res.status = pages_alloc(rq.bytes, offset, order);
        if (res.status == bpa_pkg::ST_OK) begin
          res.offset = offset[25:0];
          res.order = order[3:0];
        end
      end
      bpa_pkg::CMD_FREE: res.status = pages_free(rq.offset);
      default: ;
    endcase
    for (int k = 0; k < bpa_pkg::ORDERS; k++) begin
      if (hd[k] < bpa_pkg::PAGES) begin
        res.largest = k[3:0];
        res.any_free = 1'b1;
      end
    end
    res.free_pages = free_tot[10:0];
    return res;
  endfunction

  // Predicts a request, queues it for the driver and keeps the list of live blocks.
  task automatic issue(bpa_pkg::cmd_e cmd, logic [25:0] bytes, logic [25:0] offset);
    alloc_req_t rq;
    alloc_res_t res;
    rq.cmd = cmd;
    rq.bytes = bytes;
    rq.offset = offset;
    res = predict_request(rq);
    req_pending.push_back(rq);
    res_owed.push_back(res);
    req_count++;
    cmd_seen[cmd]++;
    status_seen[res.status]++;
    if (cmd == bpa_pkg::CMD_INIT) begin
      live_blocks.delete();
      freed_blocks.delete();
    end else if (cmd == bpa_pkg::CMD_ALLOC && res.status == bpa_pkg::ST_OK) begin
      live_blocks.push_back(res.offset);
    end else if (cmd == bpa_pkg::CMD_FREE && res.status == bpa_pkg::ST_OK) begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == offset) begin
          live_blocks.delete(i);
          break;
        end
      end
      freed_blocks.push_back(offset);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
    end
  endtask

  // Waits until every request has gone through and its result has arrived.
  task automatic wait_idle();
    while (req_pending.size() != 0 || res_owed.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic reg_write(int index, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == bpa_pkg::REG_PAGE_SHIFT) shift_reg = value & 32'h1f;
    else count_reg = value & 32'h7ff;
  endtask

  // A random size, mostly a few pages, occasionally anything at all.
  function automatic logic [25:0] random_size();
    int sh, ord;
    sh = eff_shift();
    if ($urandom_range(19) == 0) return 26'($urandom());
    ord = ($urandom_range(3) == 0) ? $urandom_range(bpa_pkg::TOP) : $urandom_range(2);
    return 26'($urandom_range(1, 1 << (sh + ord)));
  endfunction

  task automatic random_request();
    int          pick;
    logic [25:0] off;
    pick = $urandom_range(99);
    if (pick < 45) begin
      issue(bpa_pkg::CMD_ALLOC, random_size(), 26'($urandom()));
    end else if (pick < 85) begin
      if (live_blocks.size() != 0 && $urandom_range(9) < 8) begin
        off = live_blocks[$urandom_range(live_blocks.size() - 1)];
      end else if (freed_blocks.size() != 0 && $urandom_range(1) == 0) begin
        off = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
      end else begin
        off = 26'($urandom());
        if ($urandom_range(1) == 0) off = off >> $urandom_range(25);
      end
      issue(bpa_pkg::CMD_FREE, 26'($urandom()), off);
    end else if (pick < 98) begin
      issue(bpa_pkg::CMD_QUERY, 26'($urandom()), 26'($urandom()));
    end else begin
      issue(bpa_pkg::CMD_INIT, 26'($urandom()), 26'($urandom()));
    end
  endtask

  // Sender: bursts of random length separated by random gaps, some of them empty.
  logic req_taken = 1'b0;
  int   burst_left = 4;
  int   gap_left = 0;

  always @(negedge clk_i) begin
    alloc_req_t rq;
    if (s_axis_tvalid && !req_taken) begin
      // Request still waiting for tready: hold it.
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (req_pending.size() != 0) begin
      rq = req_pending.pop_front();
      s_axis_tdata <= {4'b0, rq.offset, rq.bytes};
      s_axis_tuser <= rq.cmd;
      s_axis_tvalid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: stalls for the first part of a window whose length and duty
  // are redrawn periodically; some stretches have no stall at all.
  int cyc = 0;
  int stall_win = 7;
  int stall_len = 3;

  always @(negedge clk_i) begin
    cyc++;
    if (cyc % 400 == 0) begin
      stall_win = $urandom_range(2, 17);
      stall_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(stall_win - 1);
    end
    m_axis_tready <= (cyc % stall_win) >= stall_len;
  end

  // Result checker and watchdog, both sampling at the rising edge.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    alloc_res_t want;
    req_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_count++;
      if (res_owed.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = res_owed.pop_front();
        if (m_axis_tdata[1:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[27:2] != want.offset) begin
          $error("block_offset: expected %h, got %h", want.offset, m_axis_tdata[27:2]);
          fail_count++;
        end
        if (m_axis_tdata[31:28] != want.order) begin
          $error("block_order: expected %0d, got %0d", want.order, m_axis_tdata[31:28]);
          fail_count++;
        end
        if (m_axis_tdata[42:32] != want.free_pages) begin
          $error("free_pages: expected %0d, got %0d", want.free_pages,
                 m_axis_tdata[42:32]);
          fail_count++;
        end
        if (m_axis_tdata[46:43] != want.largest) begin
          $error("largest_free_order: expected %0d, got %0d", want.largest,
                 m_axis_tdata[46:43]);
          fail_count++;
        end
        if (m_axis_tdata[47] != want.any_free) begin
          $error("any_free: expected %0d, got %0d", want.any_free, m_axis_tdata[47]);
          fail_count++;
        end
      end
    end
    if (req_taken || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
      $display("tb_buddy_page_allocator_top failed");
      $finish;
    end
  end

  // Configurations for the random phases: {page_shift, page_count}. They take in
  // both ends of each register, out-of-range shifts and counts beyond PAGES.
  int phase_cfg[8][2] = '{'{3, 2}, '{16, 1024}, '{0, 2047}, '{31, 100},
                          '{5, 0}, '{12, 1}, '{10, 1024}, '{7, 777}};

  initial begin
    logic [25:0] held;
    pages_init();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the reset configuration of 1 KiB pages and 1024 pages.
    issue(bpa_pkg::CMD_QUERY, '0, '0);
    issue(bpa_pkg::CMD_ALLOC, '0, '0);                 // zero size
    issue(bpa_pkg::CMD_ALLOC, 26'd1, '0);
    issue(bpa_pkg::CMD_ALLOC, 26'd1024, '0);
    issue(bpa_pkg::CMD_ALLOC, 26'd1025, '0);           // rounds up to two pages
    issue(bpa_pkg::CMD_ALLOC, 26'h20000, '0);          // exactly one top-order block
    issue(bpa_pkg::CMD_ALLOC, 26'h20001, '0);          // one byte more than a top block
    issue(bpa_pkg::CMD_ALLOC, 26'h3ffffff, '0);
    issue(bpa_pkg::CMD_FREE, '0, 26'd1);               // not page aligned
    issue(bpa_pkg::CMD_FREE, '0, 26'h100000);          // just past the managed area
    issue(bpa_pkg::CMD_FREE, '0, 26'h3ffffff);
    held = live_blocks[1];
    issue(bpa_pkg::CMD_FREE, '0, held);
    issue(bpa_pkg::CMD_FREE, '0, held);                // second free of the same block
    issue(bpa_pkg::CMD_FREE, '0, 26'd3072);            // free page inside a block
    while (live_blocks.size() != 0) issue(bpa_pkg::CMD_FREE, '0, live_blocks[0]);
    issue(bpa_pkg::CMD_ALLOC, 26'd5000, '0);
    wait_idle();
    // A page shift change after allocation: the block offset is reread with it.
    reg_write(bpa_pkg::REG_PAGE_SHIFT, 12);
    issue(bpa_pkg::CMD_FREE, '0, 26'd0);
    issue(bpa_pkg::CMD_FREE, '0, 26'd4096);
    issue(bpa_pkg::CMD_QUERY, '0, '0);
    issue(bpa_pkg::CMD_INIT, 26'h3ffffff, 26'h3ffffff);

    // Random phases, each started by a configuration change and an init.
    foreach (phase_cfg[ph]) begin
      wait_idle();
      reg_write(bpa_pkg::REG_PAGE_SHIFT, phase_cfg[ph][0]);
      reg_write(bpa_pkg::REG_PAGE_COUNT, phase_cfg[ph][1]);
      issue(bpa_pkg::CMD_INIT, 26'($urandom()), 26'($urandom()));
      for (int n = 0; n < 190; n++) begin
        random_request();
        // Keep the driver's backlog short so the stall pattern matters.
        while (req_pending.size() > 8) @(posedge clk_i);
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d requests (init %0d, allocate %0d, free %0d, query %0d), %0d results.",
             req_count, cmd_seen[bpa_pkg::CMD_INIT], cmd_seen[bpa_pkg::CMD_ALLOC],
             cmd_seen[bpa_pkg::CMD_FREE], cmd_seen[bpa_pkg::CMD_QUERY], res_count);
    $display("Statuses: ok %0d, no block %0d, bad address %0d, not allocated %0d.",
             status_seen[bpa_pkg::ST_OK], status_seen[bpa_pkg::ST_NO_BLOCK],
             status_seen[bpa_pkg::ST_BAD_ADDR], status_seen[bpa_pkg::ST_NOT_ALLOC]);
    if (fail_count == 0 && res_owed.size() == 0) begin
      $display("tb_buddy_page_allocator_top passed");
    end else begin
      $display("tb_buddy_page_allocator_top failed");
    end
    $finish;
  end

endmodule
